// ===== rtl/mck_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the morse code table for the character keyer
package mck_pkg;

  localparam int unsigned DOT_W      = 16;
  localparam int unsigned UNITS_W    = 3;
  localparam int unsigned DUR_W      = DOT_W + UNITS_W;
  localparam int unsigned Q_DEPTH    = 2;

  localparam logic [DOT_W-1:0]   DOT_TIME_RESET   = 16'd200;
  localparam logic [UNITS_W-1:0] UNITS_DOT        = 3'd1;
  localparam logic [UNITS_W-1:0] UNITS_DASH       = 3'd3;
  localparam logic [UNITS_W-1:0] UNITS_ELEM_GAP   = 3'd1;
  localparam logic [UNITS_W-1:0] UNITS_SPACE      = 3'd4;
  localparam logic [UNITS_W-1:0] UNITS_LETTER_GAP = 3'd2;
  localparam logic [UNITS_W-1:0] UNITS_END_GAP    = 3'd7;
  localparam logic [UNITS_W-1:0] UNITS_NONE       = 3'd0;

  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_in_message;
  } in_beat_t;

  typedef struct packed {
    logic             lamp_on;
    logic [DUR_W-1:0] duration_ticks;
    logic             run_end;
  } out_beat_t;

  // element count and dash mask, bit i set when element i is a dash
  typedef struct packed {
    logic [2:0] elem_cnt;
    logic [3:0] dash_mask;
  } mck_code_t;

  // classified character handed from front to back
  typedef struct packed {
    mck_code_t          code;
    logic               space_gap;
    logic [UNITS_W-1:0] tail_units;
  } mck_desc_t;

  function automatic mck_code_t morse_lookup(input logic [4:0] idx);
    mck_code_t c;
    unique case (idx)
      5'd0:    c = '{3'd2, 4'b0010};
      5'd1:    c = '{3'd4, 4'b0001};
      5'd2:    c = '{3'd4, 4'b0101};
      5'd3:    c = '{3'd3, 4'b0001};
      5'd4:    c = '{3'd1, 4'b0000};
      5'd5:    c = '{3'd4, 4'b0100};
      5'd6:    c = '{3'd3, 4'b0011};
      5'd7:    c = '{3'd4, 4'b0000};
      5'd8:    c = '{3'd2, 4'b0000};
      5'd9:    c = '{3'd4, 4'b1110};
      5'd10:   c = '{3'd3, 4'b0101};
      5'd11:   c = '{3'd4, 4'b0010};
      5'd12:   c = '{3'd2, 4'b0011};
      5'd13:   c = '{3'd2, 4'b0001};
      5'd14:   c = '{3'd3, 4'b0111};
      5'd15:   c = '{3'd4, 4'b0110};
      5'd16:   c = '{3'd4, 4'b1011};
      5'd17:   c = '{3'd3, 4'b0010};
      5'd18:   c = '{3'd3, 4'b0000};
      5'd19:   c = '{3'd1, 4'b0001};
      5'd20:   c = '{3'd3, 4'b0100};
      5'd21:   c = '{3'd4, 4'b1000};
      5'd22:   c = '{3'd3, 4'b0110};
      5'd23:   c = '{3'd4, 4'b1001};
      5'd24:   c = '{3'd4, 4'b1101};
      5'd25:   c = '{3'd4, 4'b0011};
      default: c = '{3'd0, 4'b0000};
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/morse_character_keyer.sv =====
`timescale 1ns / 1ps
// top level of the morse character keyer: dot time register, front, queue, back
//
//  channel | ports                               | direction | beat
//  --------+-------------------------------------+-----------+--------------------------
//  in      | in_valid, in_stall, in_beat         | into      | one character + last flag
//  out     | out_valid, out_stall, out_beat      | out of    | one lamp interval
//  cfg     | cfg_wr_en, cfg_wr_data              | into      | dot time, no read-back
//
// a character leaves the queue only while the back end is idle; the back end sequencer
// then emits its intervals, one interval a cycle while out_stall does not hold it.
// the two-entry queue lets up to two characters be taken while the back end is busy.
// rst_n is synchronous and active low; it empties the queue and the output register
// and sets dot time to 200.
// an out_stall with out_valid high holds the output register and a busy sequencer; in_stall
// rises only when the queue is full.
module morse_character_keyer
  import mck_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_beat,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_beat,
  input  logic             cfg_wr_en,
  input  logic [DOT_W-1:0] cfg_wr_data
);

  logic [DOT_W-1:0] dot_time_r;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_not_empty;
  mck_desc_t        q_wdata;
  mck_desc_t        q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_time_r <= DOT_TIME_RESET;
    end else if (cfg_wr_en) begin
      dot_time_r <= cfg_wr_data;
    end
  end

  mck_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  mck_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  mck_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .dot_time    (dot_time_r),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_beat    (out_beat)
  );

endmodule

// ===== rtl/mck_front.sv =====
`timescale 1ns / 1ps
// front end: accepts characters and classifies them into interval descriptors
module mck_front
  import mck_pkg::*;
(
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  input  logic      q_full,
  output logic      q_push,
  output mck_desc_t q_wdata
);

  logic       is_letter;
  logic       is_space;
  logic [4:0] letter_idx;

  assign is_letter  = (in_beat.char_code >= CHAR_A) && (in_beat.char_code <= CHAR_Z);
  assign is_space   = (in_beat.char_code == CHAR_SPACE);
  // 'A' is 0x41, so the low five bits minus one give the letter index
  assign letter_idx = in_beat.char_code[4:0] - 5'd1;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.code      = is_letter ? morse_lookup(letter_idx) : mck_code_t'('0);
    q_wdata.space_gap = is_space;
    if (in_beat.last_in_message) begin
      q_wdata.tail_units = UNITS_END_GAP;
    end else if (!is_space) begin
      q_wdata.tail_units = UNITS_LETTER_GAP;
    end else begin
      q_wdata.tail_units = UNITS_NONE;
    end
  end

endmodule

// ===== rtl/mck_queue.sv =====
`timescale 1ns / 1ps
// two-entry descriptor queue between front and back
module mck_queue
  import mck_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mck_desc_t wdata,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output mck_desc_t rdata
);

  mck_desc_t  mem_r [Q_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'(Q_DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/mck_back.sv =====
`timescale 1ns / 1ps
// back end: walks one descriptor and emits lamp intervals through an output register
module mck_back
  import mck_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DOT_W-1:0] dot_time,
  input  logic             q_not_empty,
  input  mck_desc_t        q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_beat
);

  typedef enum logic [2:0] {
    IDLE,
    ELEM_ON,
    ELEM_OFF,
    SPACE,
    TAIL
  } phase_t;

  phase_t    phase_r, phase_nxt;
  logic [1:0] idx_r, idx_nxt;
  mck_desc_t desc_r;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r, out_beat_nxt;

  logic               out_load;
  logic               is_dash;
  logic [UNITS_W-1:0] units;
  logic               lamp;
  logic               last_elem;
  phase_t             after_elems;

  assign out_load  = !out_valid_r || !out_stall;
  assign q_pop     = (phase_r == IDLE) && q_not_empty;
  assign is_dash   = desc_r.code.dash_mask[idx_r];
  assign last_elem = ({1'b0, idx_r} + 3'd1) == desc_r.code.elem_cnt;
  assign after_elems = (desc_r.tail_units != UNITS_NONE) ? TAIL : IDLE;

  always_comb begin
    units = UNITS_NONE;
    lamp  = 1'b0;
    unique case (phase_r)
      IDLE:     units = UNITS_NONE;
      ELEM_ON: begin
        units = is_dash ? UNITS_DASH : UNITS_DOT;
        lamp  = 1'b1;
      end
      ELEM_OFF: units = UNITS_ELEM_GAP;
      SPACE:    units = UNITS_SPACE;
      TAIL:     units = desc_r.tail_units;
      default:  units = UNITS_NONE;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (phase_r == IDLE) begin
      if (q_not_empty) begin
        idx_nxt = 2'd0;
        if (q_rdata.code.elem_cnt != 3'd0) begin
          phase_nxt = ELEM_ON;
        end else if (q_rdata.space_gap) begin
          phase_nxt = SPACE;
        end else begin
          phase_nxt = TAIL;
        end
      end
    end else if (out_load) begin
      unique case (phase_r)
        ELEM_ON:  phase_nxt = ELEM_OFF;
        ELEM_OFF: begin
          if (last_elem) begin
            phase_nxt = after_elems;
          end else begin
            phase_nxt = ELEM_ON;
            idx_nxt   = idx_r + 2'd1;
          end
        end
        SPACE:    phase_nxt = after_elems;
        TAIL:     phase_nxt = IDLE;
        default:  phase_nxt = IDLE;
      endcase
      out_valid_nxt               = 1'b1;
      out_beat_nxt.lamp_on        = lamp;
      out_beat_nxt.duration_ticks = DUR_W'(units) * DUR_W'(dot_time);
      out_beat_nxt.run_end        = (phase_nxt == IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= IDLE;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_beat_r  <= out_beat_nxt;
      if (q_pop) begin
        desc_r <= q_rdata;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTHESIS
  a_lamp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.lamp_on) |-> !out_beat_r.run_end)
    else $error("lit interval marked as end of run");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ELEM_ON || phase_r == ELEM_OFF) |-> ({1'b0, idx_r} < desc_r.code.elem_cnt))
    else $error("element index past element count");

  a_tail_has_units: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == TAIL) |-> (desc_r.tail_units != UNITS_NONE))
    else $error("tail gap phase with no gap length");

  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (phase_r != IDLE))
    else $error("descriptor taken but sequencer stayed idle");
`endif

endmodule

// ===== tb/tb_morse_character_keyer.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the morse character keyer: predicted lamp intervals vs dut beats
module tb_morse_character_keyer
  import mck_pkg::*;
;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 390;
  localparam int unsigned PHASE_ITEMS   = 70;
  localparam int unsigned HOLD_CYCLES   = 300;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_beat_t         in_beat = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_beat;
  logic             cfg_wr_en = 1'b0;
  logic [DOT_W-1:0] cfg_wr_data = DOT_TIME_RESET;

  // testbench copy of the dot time register
  logic [DOT_W-1:0] dot_time_cfg = DOT_TIME_RESET;
  out_beat_t        expected_intervals[$];
  int unsigned      mismatches = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      random_items = 0;
  int unsigned      hold_cycles = 0;
  bit               tx_idle_on = 1'b1;
  bit               rx_idle_on = 1'b1;

  morse_character_keyer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic string letter_pattern(input int idx);
    case (idx)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      25: return "--..";
      default: return "";
    endcase
  endfunction

  function automatic void queue_interval(input logic lamp, input logic [UNITS_W-1:0] units,
                                         input logic fin);
    out_beat_t b;
    b.lamp_on        = lamp;
    // product kept to the 19-bit field width
    b.duration_ticks = {{UNITS_W{1'b0}}, dot_time_cfg} * {{DOT_W{1'b0}}, units};
    b.run_end        = fin;
    expected_intervals.push_back(b);
  endfunction

  function automatic void predict_intervals(input logic [7:0] c, input logic last);
    string pat;
    int    i;
    if (c >= CHAR_A && c <= CHAR_Z) begin
      pat = letter_pattern(int'(c - CHAR_A));
      for (i = 0; i < pat.len(); i++) begin
        queue_interval(1'b1, (pat.getc(i) == "-") ? UNITS_DASH : UNITS_DOT, 1'b0);
        queue_interval(1'b0, UNITS_ELEM_GAP, 1'b0);
      end
    end
    if (c == CHAR_SPACE) begin
      queue_interval(1'b0, UNITS_SPACE, !last);
    end else if (!last) begin
      queue_interval(1'b0, UNITS_LETTER_GAP, 1'b1);
    end
    if (last) begin
      queue_interval(1'b0, UNITS_END_GAP, 1'b1);
    end
  endfunction

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                  <= 1'b1;
    in_beat.char_code         <= c;
    in_beat.last_in_message   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_intervals(c, last);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_intervals.size() != 0) @(posedge clk);
  endtask

  task automatic write_dot_time(input logic [DOT_W-1:0] value);
    cfg_wr_data  <= value;
    cfg_wr_en    <= 1'b1;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    dot_time_cfg = value;
  endtask

  // receiver: random stall per beat, plus a long hold-off on request
  initial begin : receiver
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      n = rx_idle_on ? $urandom_range(0, 13) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_intervals
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_intervals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected interval: lamp %0b ticks %0d end %0b",
                   out_beat.lamp_on, out_beat.duration_ticks, out_beat.run_end);
      end else begin
        want = expected_intervals.pop_front();
        if (out_beat.lamp_on !== want.lamp_on ||
            out_beat.duration_ticks !== want.duration_ticks ||
            out_beat.run_end !== want.run_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("interval mismatch: exp %0b %0d %0b, got %0b %0d %0b",
                     want.lamp_on, want.duration_ticks, want.run_end,
                     out_beat.lamp_on, out_beat.duration_ticks, out_beat.run_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("morse_character_keyer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset value of dot time, every letter class, space, uncoded codes
  task automatic test_directed_chars;
    send_char("A", 1'b0);
    send_char("E", 1'b0);
    send_char("T", 1'b0);
    send_char("Y", 1'b0);
    send_char("Z", 1'b0);
    send_char("Q", 1'b1);
    send_char(" ", 1'b0);
    send_char(" ", 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char("a", 1'b0);
    send_char("@", 1'b0);
    send_char("[", 1'b0);
    send_char("z", 1'b1);
    send_char("S", 1'b0);
    send_char("O", 1'b0);
    send_char("S", 1'b1);
    drain();
  endtask

  task automatic test_dot_time_extremes;
    write_dot_time(16'd1);
    send_char("H", 1'b0);
    send_char(" ", 1'b1);
    drain();
    write_dot_time(16'hFFFF);
    send_char("O", 1'b0);
    send_char("J", 1'b1);
    drain();
    // with a dot time of zero, durations collapse to zero
    write_dot_time(16'd0);
    send_char("K", 1'b0);
    send_char(" ", 1'b1);
    drain();
  endtask

  // receiver holds off while the sender keeps offering, input side must stall
  task automatic test_backpressure;
    int i;
    write_dot_time(16'd3);
    tx_idle_on  = 1'b0;
    hold_cycles = HOLD_CYCLES;
    for (i = 0; i < 20; i++) begin
      send_char(CHAR_A + 8'($urandom_range(0, 25)), (i == 19));
    end
    drain();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_messages;
    int          len;
    int          i;
    int unsigned phase_items;
    logic [7:0]  c;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       write_dot_time(16'($urandom_range(1, 8)));
        1:       write_dot_time(16'($urandom_range(1, 65535)));
        2:       write_dot_time(16'($urandom_range(60000, 65535)));
        default: write_dot_time(16'($urandom_range(1, 1000)));
      endcase
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_idle_on  = ($urandom_range(0, 3) != 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          // well-formed message, last flag only on the final character
          len = $urandom_range(1, 8);
          for (i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 5) == 0) c = CHAR_SPACE;
            else c = CHAR_A + 8'($urandom_range(0, 25));
            send_char(c, (i == len - 1));
          end
          phase_items += len;
          random_items += len;
        end else begin
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          phase_items++;
          random_items++;
        end
      end
      drain();
    end
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_chars();
    test_dot_time_extremes();
    test_backpressure();
    test_random_messages();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_intervals.size() == 0) begin
      $display("morse_character_keyer test passed");
    end else begin
      $display("morse_character_keyer test failed");
    end
    $finish;
  end

endmodule

// ===== morse_character_keyer.f =====
rtl/mck_pkg.sv
rtl/mck_front.sv
rtl/mck_queue.sv
rtl/mck_back.sv
rtl/morse_character_keyer.sv
tb/tb_morse_character_keyer.sv
